>>> rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the byte-stream SHA-256 hasher: request
// kinds, sequencer states, initial hash values and round constants.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam logic REQ_ABSORB = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] FILL_LAST_ZERO = 6'd55;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	localparam logic [31:0] INIT_HASH [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

>>> rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream with one shared round unit run by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries requests: s_tuser = 0 absorbs the byte in s_tdata,
//   s_tuser = 1 finishes the message. s_tready is high only while idle.
//   An absorb shifts its byte into the block; the byte that fills a 64-byte
//   block starts a compression (64 rounds on one round unit, then a fold).
//   A finish pads the message one byte per cycle through the same byte
//   shift line, pausing while a full block is compressed; for f buffered
//   bytes it compresses one block, or two when f >= 56.
//   The digest then leaves on the master channel as eight 32-bit words,
//   word 0 first, m_tuser giving the word index and m_tlast marking the
//   eighth; one word per cycle while m_tready is high. A stalled receiver
//   simply holds the current word; no request is taken until all eight
//   words are gone. After the last word the chaining state returns to the
//   initial hash values for the next message.
//   arst_n clears the sequencer, byte count and fill level and loads the
//   initial hash values at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last_word
);

	sha256_pkg::state_t state_q, state_d, ret_q, ret_d;

	logic [31:0] chain_q [0:7];
	logic [31:0] v_q [0:7];
	logic [31:0] w_q [0:15];
	logic [63:0] msg_q;
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;

	logic        shift_en;
	logic [7:0]  shift_byte;
	logic        absorb;
	logic        finish;
	logic        block_full;

	logic [31:0] big1, ch, t1, big0, maj, t2, ws0, ws1, w_new;

	assign absorb = s_tvalid && s_tready && (s_tuser == sha256_pkg::REQ_ABSORB);
	assign finish = s_tvalid && s_tready && (s_tuser == sha256_pkg::REQ_FINISH);
	assign block_full = shift_en && (fill_q == sha256_pkg::FILL_LAST);

	// round unit
	always_comb begin
		big1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + ch + sha256_pkg::ROUND_K[rnd_q] + w_q[0];
		big0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + maj;
		ws0 = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		ws1 = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10);
		w_new = w_q[0] + ws0 + w_q[9] + ws1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (finish) begin
					state_d = sha256_pkg::ST_PAD_ONE;
				end else if (block_full) begin
					state_d = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_PAD_ONE, sha256_pkg::ST_PAD_ZERO: begin
				if (fill_q == sha256_pkg::FILL_LAST) begin
					state_d = sha256_pkg::ST_ROUND;
				end else if (fill_q == sha256_pkg::FILL_LAST_ZERO) begin
					state_d = sha256_pkg::ST_PAD_LEN;
				end else begin
					state_d = sha256_pkg::ST_PAD_ZERO;
				end
			end
			sha256_pkg::ST_PAD_LEN: begin
				if (fill_q == sha256_pkg::FILL_LAST) begin
					state_d = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_ROUND: begin
				if (rnd_q == sha256_pkg::ROUND_LAST) begin
					state_d = sha256_pkg::ST_FOLD;
				end
			end
			sha256_pkg::ST_FOLD: begin
				state_d = ret_q;
			end
			sha256_pkg::ST_OUT: begin
				if (m_tready && idx_q == sha256_pkg::WORD_LAST) begin
					state_d = sha256_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		shift_en = 1'b0;
		shift_byte = s_tdata;
		ret_d = sha256_pkg::ST_PAD_ZERO;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				shift_en = s_tvalid && (s_tuser == sha256_pkg::REQ_ABSORB);
				ret_d = sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_PAD_ONE: begin
				shift_en = 1'b1;
				shift_byte = sha256_pkg::PAD_BYTE;
			end
			sha256_pkg::ST_PAD_ZERO: begin
				shift_en = 1'b1;
				shift_byte = 8'h00;
			end
			sha256_pkg::ST_PAD_LEN: begin
				shift_en = 1'b1;
				shift_byte = len_q[63:56];
				ret_d = sha256_pkg::ST_OUT;
			end
			sha256_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign m_tdata = chain_q[idx_q];
	assign m_tuser = idx_q;
	assign m_tlast = (idx_q == sha256_pkg::WORD_LAST);

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			ret_q <= sha256_pkg::ST_IDLE;
			msg_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256_pkg::INIT_HASH[i];
			end
		end else begin
			state_q <= state_d;
			if (block_full) begin
				ret_q <= ret_d;
			end
			if (absorb) begin
				msg_q <= msg_q + 64'd1;
			end
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == sha256_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == sha256_pkg::ST_FOLD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			if (m_tvalid && m_tready) begin
				idx_q <= idx_q + 3'd1;
				if (m_tlast) begin
					msg_q <= '0;
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= sha256_pkg::INIT_HASH[i];
					end
				end
			end
		end
	end

	// block shift line, message schedule window, working variables
	always_ff @(posedge clk) begin
		if (finish) begin
			len_q <= {msg_q[60:0], 3'b000};
		end else if (state_q == sha256_pkg::ST_PAD_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], shift_byte};
		end else if (state_q == sha256_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (block_full) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (state_q == sha256_pkg::ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request taken while digest pending");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == sha256_pkg::REQ_FINISH) |=>
		(!s_tready && !m_tvalid))
		else $error("finish did not start padding");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_q == 6'd0))
		else $error("not idle after last digest word");

	a_round_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_ROUND && rnd_q == sha256_pkg::ROUND_LAST) |=>
		(state_q == sha256_pkg::ST_FOLD && rnd_q == 6'd0))
		else $error("compression did not end in fold");
`endif

endmodule

>>> tb/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_tb
// Streams byte and finish requests into the hasher and scores each digest
// word against a SHA-256 scoreboard model. The model keeps its own chaining
// words, block buffer, byte count and fill level. Directed messages cover the
// empty message, the byte extremes and a known vector. Random messages cover
// the padding boundaries around 56 and 64 buffered bytes and short messages.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 200;

	localparam logic [31:0] IV_WORDS [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_WORDS [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;                   // data_byte
	logic        s_tuser = sha256_pkg::REQ_ABSORB;  // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;                           // digest_word
	logic [2:0]  m_tuser;                           // word_index
	logic        m_tlast;                           // last_word

	byte_req_t    req_queue [$];
	digest_word_t digest_queue [$];
	byte_req_t    next_req;
	digest_word_t want_word;

	logic [31:0] chain [0:7];
	logic [7:0]  blk [0:63];
	logic [63:0] byte_count;
	logic [5:0]  fill;

	int          fail_cnt = 0;
	int          idle_cycles = 0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          random_reqs = 0;
	int          random_msgs = 0;
	int          lens [$];
	int          pick;
	logic [15:0] cyc = '0;
	logic        quiet;

	assign quiet = (cyc[9:8] == 2'b11);

	sha256_byte_stream_hasher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_restart();
		for (int i = 0; i < 8; i++)
			chain[i] = IV_WORDS[i];
		byte_count = '0;
		fill = '0;
	endfunction

	function automatic void fold_block();
		logic [31:0] w [0:63];
		logic [31:0] v [0:7];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rot_right(w[i - 15], 7) ^ rot_right(w[i - 15], 18) ^ (w[i - 15] >> 3);
			s1 = rot_right(w[i - 2], 17) ^ rot_right(w[i - 2], 19) ^ (w[i - 2] >> 10);
			w[i] = w[i - 16] + s0 + w[i - 7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			s1 = rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_WORDS[i] + w[i];
			s0 = rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function automatic void hash_request(input logic kind, input logic [7:0] data);
		logic [63:0]  bit_len;
		int           pos;
		digest_word_t dw;
		if (kind == sha256_pkg::REQ_ABSORB) begin
			blk[fill] = data;
			byte_count = byte_count + 64'd1;
			fill = fill + 6'd1;
			if (fill == 6'd0)
				fold_block();
		end else begin
			bit_len = byte_count << 3;
			pos = fill;
			blk[pos] = 8'h80;  // pad marker
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					blk[pos] = 8'h00;
					pos++;
				end
				fold_block();
				pos = 0;
			end
			while (pos < 56) begin
				blk[pos] = 8'h00;
				pos++;
			end
			for (int i = 0; i < 8; i++)
				blk[56 + i] = bit_len[63 - 8 * i -: 8];
			fold_block();
			for (int i = 0; i < 8; i++) begin
				dw.word = chain[i];
				dw.index = 3'(i);
				dw.last = (i == 7);
				digest_queue.push_back(dw);
			end
			hash_restart();
		end
	endfunction

	task automatic add_req(input logic kind, input logic [7:0] data);
		byte_req_t r;
		r.kind = kind;
		r.data = data;
		req_queue.push_back(r);
	endtask

	task automatic add_random_message(input int len);
		for (int i = 0; i < len; i++)
			add_req(sha256_pkg::REQ_ABSORB, 8'($urandom));
		add_req(sha256_pkg::REQ_FINISH, 8'($urandom));
		random_reqs += len + 1;
		random_msgs++;
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tuser <= sha256_pkg::REQ_ABSORB;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				hash_request(s_tuser, s_tdata);
				send_gap = quiet ? 0 : $urandom_range(0, 4);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					next_req = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_req.data;
					s_tuser <= next_req.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// digest monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_queue.size() == 0) begin
					fail_cnt++;
					$display("%0t unexpected digest word: expected none, actual %h idx %0d last %0b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want_word = digest_queue.pop_front();
					if (m_tdata !== want_word.word || m_tuser !== want_word.index ||
							m_tlast !== want_word.last) begin
						fail_cnt++;
						$display("%0t digest mismatch: expected %h idx %0d last %0b, actual %h idx %0d last %0b",
							$time, want_word.word, want_word.index, want_word.last,
							m_tdata, m_tuser, m_tlast);
					end
				end
				recv_stall = quiet ? 0 : $urandom_range(0, 4);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		cyc <= cyc + 16'd1;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		hash_restart();

		// empty messages back to back, then byte extremes and a known vector
		add_req(sha256_pkg::REQ_FINISH, 8'h00);
		add_req(sha256_pkg::REQ_FINISH, 8'hff);
		add_req(sha256_pkg::REQ_ABSORB, 8'h00);
		add_req(sha256_pkg::REQ_FINISH, 8'h00);
		add_req(sha256_pkg::REQ_ABSORB, 8'hff);
		add_req(sha256_pkg::REQ_FINISH, 8'hff);
		add_req(sha256_pkg::REQ_ABSORB, 8'h61);
		add_req(sha256_pkg::REQ_ABSORB, 8'h62);
		add_req(sha256_pkg::REQ_ABSORB, 8'h63);
		add_req(sha256_pkg::REQ_FINISH, 8'h00);
		add_req(sha256_pkg::REQ_ABSORB, 8'hff);
		add_req(sha256_pkg::REQ_ABSORB, 8'h00);
		add_req(sha256_pkg::REQ_ABSORB, 8'hff);
		add_req(sha256_pkg::REQ_FINISH, 8'h5a);

		// padding boundaries: length fits, extra block, pad byte ends a block
		lens = '{55, 56, 63};
		while (lens.size() != 0) begin
			pick = $urandom_range(0, lens.size() - 1);
			add_random_message(lens[pick]);
			lens.delete(pick);
		end
		while (random_reqs < 210 || random_msgs < 6) begin
			if ($urandom_range(0, 5) == 0)
				add_random_message($urandom_range(56, 72));
			else
				add_random_message($urandom_range(0, 20));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (req_queue.size() != 0 || s_tvalid || digest_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (digest_queue.size() != 0) begin
			fail_cnt++;
			$display("%0t %0d digest words never arrived", $time, digest_queue.size());
		end
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
